/* hw/rtl/hierarchical_bitmap_find_first_macros.svh */
// Assertion helpers for the bitmap find-first block.
`ifndef HIERARCHICAL_BITMAP_FIND_FIRST_MACROS_SVH
`define HIERARCHICAL_BITMAP_FIND_FIRST_MACROS_SVH

// Same-cycle implication, masked during reset.
`define HBFF_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hbff: same-cycle check failed");

// Next-cycle implication, masked during reset.
`define HBFF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hbff: next-cycle check failed");

`endif

/* hw/rtl/hbff_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package hbff_pkg;

  // Pyramid geometry: 4096 flags, 16-bit words, three levels.
  localparam int WORD_LOG2  = 4;
  localparam int WORD_BITS  = 1 << WORD_LOG2;
  localparam int MAP_LOG2   = 12;
  localparam int SPAN_LOG2  = MAP_LOG2 - WORD_LOG2;
  localparam int LEAF_AW    = SPAN_LOG2;
  localparam int LEAF_COUNT = 1 << LEAF_AW;
  localparam int MID_AW     = SPAN_LOG2 - WORD_LOG2;
  localparam int MID_COUNT  = 1 << MID_AW;
  localparam int TOP_ACT    = SPAN_LOG2 % WORD_LOG2;

  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [WORD_LOG2-1:0]  bitpos_t;
  typedef logic [MAP_LOG2-1:0]   pos_t;
  typedef logic [LEAF_AW-1:0]    leaf_addr_t;
  typedef logic [MID_AW-1:0]     mid_addr_t;
  typedef logic [2:0]            op_t;

  // Top word after a fill: only the active bits when the top is partly used.
  localparam word_t TOP_FILL = (TOP_ACT == 0) ? '1 :
                               word_t'((1 << (1 << TOP_ACT)) - 1);

  localparam op_t OP_GET  = 3'd0;
  localparam op_t OP_SET  = 3'd1;
  localparam op_t OP_FIND = 3'd2;
  localparam op_t OP_POP  = 3'd3;
  localparam op_t OP_FILL = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TOP,
    ST_MID,
    ST_LEAF,
    ST_UP,
    ST_FILL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic top_step;
    logic mid_step;
    logic leaf_step;
    logic leaf_get;
    logic leaf_find;
    logic leaf_write;
    logic up_step;
    logic fill_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    op_t  in_op;
    op_t  op_q;
    logic top_zero;
  } status_t;

  // Trailing-zero count; zero word gives 0.
  function automatic bitpos_t tz(word_t w);
    bitpos_t n;
    n = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) n = bitpos_t'(i);
    end
    return n;
  endfunction

  function automatic word_t put_bit(word_t w, bitpos_t sel, logic b);
    word_t one;
    one = word_t'(1) << sel;
    return b ? (w | one) : (w & ~one);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/hbff_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface hbff_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [11:0] index;
  logic        value;

  modport source (output valid, output op, output index, output value, input ready);
  modport sink   (input valid, input op, input index, input value, output ready);
endinterface

interface hbff_out_if;
  logic        valid;
  logic        ready;
  logic        bit_state;
  logic [11:0] first_index;
  logic        is_empty;

  modport source (output valid, output bit_state, output first_index, output is_empty,
                  input ready);
  modport sink   (input valid, input bit_state, input first_index, input is_empty,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/hbff_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module hbff_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/hbff_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module hbff_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  input  hbff_pkg::status_t status,
  output hbff_pkg::cmd_t    cmd
);

  import hbff_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  assign req_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          case (status.in_op)
            OP_GET, OP_SET:  state_next = ST_LEAF;
            OP_FIND, OP_POP: state_next = ST_TOP;
            OP_FILL:         state_next = ST_FILL;
            default:         state_next = ST_DONE;
          endcase
        end
      end
      ST_TOP: begin
        cmd.top_step = 1'b1;
        state_next   = status.top_zero ? ST_DONE : ST_MID;
      end
      ST_MID: begin
        cmd.mid_step = 1'b1;
        state_next   = ST_LEAF;
      end
      ST_LEAF: begin
        cmd.leaf_step = 1'b1;
        state_next    = ST_DONE;
        case (status.op_q)
          OP_GET: cmd.leaf_get = 1'b1;
          OP_SET: begin
            cmd.leaf_write = 1'b1;
            state_next     = ST_UP;
          end
          OP_FIND: cmd.leaf_find = 1'b1;
          OP_POP: begin
            cmd.leaf_find  = 1'b1;
            cmd.leaf_write = 1'b1;
            state_next     = ST_UP;
          end
          default: ;
        endcase
      end
      ST_UP: begin
        cmd.up_step = 1'b1;
        state_next  = ST_DONE;
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        state_next    = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!rsp_valid || rsp_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/hbff_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module hbff_dp (
  input  logic              clk,
  input  logic              rst,
  input  hbff_pkg::cmd_t    cmd,
  output hbff_pkg::status_t status,
  input  logic [2:0]        in_op,
  input  logic [11:0]       in_index,
  input  logic              in_value,
  output logic              rsp_bit_state,
  output logic [11:0]       rsp_first_index,
  output logic              rsp_is_empty
);

  import hbff_pkg::*;

  op_t    op_q;
  logic   value_q;
  pos_t   pos;
  logic   res_bit;
  logic   res_empty;
  logic   carry;
  logic   fill;
  logic [LEAF_COUNT-1:0] leaf_valid;
  word_t  mid_words [MID_COUNT];
  word_t  top_word;

  mid_addr_t  top_sel;
  bitpos_t    mid_sel;
  leaf_addr_t leaf_addr;
  leaf_addr_t raddr;
  word_t      rdata;
  word_t      mid_word;
  word_t      leaf_word;
  bitpos_t    leaf_sel;
  word_t      leaf_new;
  word_t      mid_new;

  assign top_sel   = pos[MAP_LOG2-1 -: MID_AW];
  assign mid_sel   = pos[LEAF_AW-1 -: WORD_LOG2];
  assign leaf_addr = pos[MAP_LOG2-1 -: LEAF_AW];
  assign mid_word  = mid_words[top_sel];

  // leaf read is issued at accept (get/set) or during the middle search
  always_comb begin
    if (cmd.accept) raddr = in_index[MAP_LOG2-1 -: LEAF_AW];
    else if (cmd.mid_step) raddr = {top_sel, tz(mid_word)};
    else raddr = leaf_addr;
  end

  hbff_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (LEAF_COUNT)
  ) u_leaf_ram (
    .clk   (clk),
    .we    (cmd.leaf_step && cmd.leaf_write),
    .waddr (leaf_addr),
    .wdata (leaf_new),
    .raddr (raddr),
    .rdata (rdata)
  );

  // unwritten leaves read as the fill pattern
  assign leaf_word = leaf_valid[leaf_addr] ? rdata : {WORD_BITS{fill}};
  assign leaf_sel  = cmd.leaf_find ? tz(leaf_word) : pos[WORD_LOG2-1:0];
  assign leaf_new  = put_bit(leaf_word, leaf_sel, cmd.leaf_find ? 1'b0 : value_q);
  assign mid_new   = put_bit(mid_word, mid_sel, carry);

  assign status.in_op    = in_op;
  assign status.op_q     = op_q;
  assign status.top_zero = (top_word == '0);

  // stores
  always_ff @(posedge clk) begin
    if (rst) begin
      leaf_valid <= '0;
      fill       <= 1'b0;
      top_word   <= '0;
      for (int i = 0; i < MID_COUNT; i++) mid_words[i] <= '0;
    end else if (cmd.fill_step) begin
      leaf_valid <= '0;
      fill       <= value_q;
      top_word   <= value_q ? TOP_FILL : '0;
      for (int i = 0; i < MID_COUNT; i++) mid_words[i] <= {WORD_BITS{value_q}};
    end else begin
      if (cmd.leaf_step && cmd.leaf_write) leaf_valid[leaf_addr] <= 1'b1;
      if (cmd.up_step) begin
        mid_words[top_sel] <= mid_new;
        top_word[top_sel]  <= (mid_new != '0);
      end
    end
  end

  // item and walk registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q      <= in_op;
      value_q   <= in_value;
      pos       <= in_index;
      res_bit   <= 1'b0;
      res_empty <= 1'b0;
    end
    if (cmd.top_step) begin
      if (top_word == '0) res_empty <= 1'b1;
      else pos[MAP_LOG2-1 -: MID_AW] <= mid_addr_t'(tz(top_word));
    end
    if (cmd.mid_step) pos[LEAF_AW-1 -: WORD_LOG2] <= tz(mid_word);
    if (cmd.leaf_step) begin
      if (cmd.leaf_find) pos[WORD_LOG2-1:0] <= leaf_sel;
      if (cmd.leaf_get) res_bit <= leaf_word[pos[WORD_LOG2-1:0]];
      carry <= (leaf_new != '0);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp_bit_state   <= res_bit;
      rsp_is_empty    <= res_empty;
      rsp_first_index <= ((op_q == OP_FIND || op_q == OP_POP) && !res_empty) ? pos : '0;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/hierarchical_bitmap_find_first.sv */
// Hierarchical bitmap of 4096 flags with find-first-set.
// req (sink): op, index, value. op 0 reads a flag, 1 writes a flag, 2 finds
//   the lowest set flag, 3 finds and clears it, 4 sets or clears every flag.
// rsp (source): one beat per req beat: bit_state, first_index, is_empty.
// One item is in flight at a time; req.ready is high only while idle.
// Get and set go straight to the leaf, find and pop start at the top
//   word, set all is a fill step; req.ready returns once the result
//   is loaded. Each level of the pyramid costs one step: a trailing-zero
//   search of the top word, one of the middle word, then the leaf word
//   from its RAM (registered read), and for set/pop a leaf write followed
//   by one step updating middle and top words.
// Leaf words sit in a 256 x 16 RAM with a valid flop per word; an invalid
//   word reads as the current fill pattern, so reset and set all need no
//   clearing pass.
// Reset empties the map and drops any pending rsp beat.
// A stalled rsp holds in its output register; the next req is taken and
//   worked on, waiting before loading its result until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module hierarchical_bitmap_find_first (
  input logic        clk,
  input logic        rst,
  hbff_in_if.sink    req,
  hbff_out_if.source rsp
);

  import hbff_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer: one state per pyramid step
  hbff_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // word stores, walk position and output register
  hbff_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .in_op           (req.op),
    .in_index        (req.index),
    .in_value        (req.value),
    .rsp_bit_state   (rsp.bit_state),
    .rsp_first_index (rsp.first_index),
    .rsp_is_empty    (rsp.is_empty)
  );

endmodule

`default_nettype wire

/* hw/rtl/hbff_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "hierarchical_bitmap_find_first_macros.svh"

module hbff_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        rsp_bit_state,
  input logic [11:0] rsp_first_index,
  input logic        rsp_is_empty
);

  // stalled result holds
  `HBFF_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_first_index) && $stable(rsp_is_empty) && $stable(rsp_bit_state))
  // one item in flight: ready drops after a beat
  `HBFF_ASSERT_NEXT(a_one_in_flight, clk, rst, req_valid && req_ready, !req_ready)
  // empty search reports index zero
  `HBFF_ASSERT_SAME(a_empty_index, clk, rst, rsp_valid && rsp_is_empty, rsp_first_index == 12'd0)
  // a read result and an empty search never coincide
  `HBFF_ASSERT_SAME(a_bit_excl, clk, rst, rsp_valid, !(rsp_bit_state && rsp_is_empty))

endmodule

bind hierarchical_bitmap_find_first hbff_checker u_hbff_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_bit_state   (rsp.bit_state),
  .rsp_first_index (rsp.first_index),
  .rsp_is_empty    (rsp.is_empty)
);

`default_nettype wire

/* tb/sv/hierarchical_bitmap_find_first_test.sv */
`timescale 1ns / 1ps

// Self-checking bench for the hierarchical bitmap.
// Requests go in one beat at a time through req_if. Each accepted beat is run
// through a local model of the flag pyramid, and the response it should give
// is queued. Every response beat on rsp_if is checked against the oldest
// queued entry, field by field.
module hierarchical_bitmap_find_first_test;
  import hbff_pkg::*;

  // Op codes 5 to 7 are unassigned; the block must answer them with zeros.
  localparam op_t OP_RSVD_FIRST = 3'd5;
  localparam op_t OP_RSVD_LAST  = 3'd7;

  // One response beat as the block should present it.
  typedef struct packed {
    logic bit_state;
    pos_t first_index;
    logic is_empty;
  } rsp_beat_t;

  logic clk = 1'b0;
  logic rst;

  hbff_in_if  req_if ();
  hbff_out_if rsp_if ();

  hierarchical_bitmap_find_first u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Model of the flag pyramid
  // ---------------------------------------------------------------------------
  // flag_words:    level 0, the flags themselves
  // summary_words: level 1, bit k set when flag word k below is non-zero
  // top_summary:   level 2, bit k set when summary word k is non-zero
  word_t flag_words    [LEAF_COUNT];
  word_t summary_words [MID_COUNT];
  word_t top_summary;

  rsp_beat_t expected_rsp[$];

  int errors         = 0;
  int sent_total     = 0;
  int beats_checked  = 0;
  int empty_searches = 0;
  int holds_done     = 0;
  int op_seen [8];

  // Shared between the test tasks and the two handshake processes.
  bit no_idle           = 1'b0;  // both sides run back to back while set
  int sink_hold_cycles  = 0;     // pending long hold-off for the receiver

  function automatic bitpos_t lowest_bit(word_t w);
    for (int i = 0; i < WORD_BITS; i++)
      if (w[i]) return bitpos_t'(i);
    return '0;
  endfunction

  // Write one flag and carry the change up: a summary bit follows whether the
  // word under it is non-empty after the write.
  function automatic void store_flag(pos_t idx, logic on);
    word_t w;
    logic  busy;
    w = flag_words[idx[MAP_LOG2-1:WORD_LOG2]];
    w[idx[WORD_LOG2-1:0]] = on;
    flag_words[idx[MAP_LOG2-1:WORD_LOG2]] = w;
    busy = |w;
    w = summary_words[idx[MAP_LOG2-1:2*WORD_LOG2]];
    w[idx[2*WORD_LOG2-1:WORD_LOG2]] = busy;
    summary_words[idx[MAP_LOG2-1:2*WORD_LOG2]] = w;
    busy = |w;
    top_summary[idx[MAP_LOG2-1:2*WORD_LOG2]] = busy;
  endfunction

  // Walk down from the top; returns 0 when the map holds no set flag.
  function automatic logic search_lowest(output pos_t hit);
    mid_addr_t  m;
    leaf_addr_t l;
    hit = '0;
    if (top_summary == '0) return 1'b0;
    m   = lowest_bit(top_summary);
    l   = {m, lowest_bit(summary_words[m])};
    hit = {l, lowest_bit(flag_words[l])};
    return 1'b1;
  endfunction

  function automatic void fill_pyramid(logic on);
    for (int i = 0; i < LEAF_COUNT; i++) flag_words[i] = on ? '1 : '0;
    for (int i = 0; i < MID_COUNT; i++) summary_words[i] = on ? '1 : '0;
    top_summary = on ? TOP_FILL : '0;
  endfunction

  // Apply one request to the model and return the response it must give.
  function automatic rsp_beat_t predict_bitmap(op_t op, pos_t index, logic value);
    rsp_beat_t r;
    pos_t      hit;
    r = '0;
    case (op)
      OP_GET: r.bit_state = flag_words[index[MAP_LOG2-1:WORD_LOG2]][index[WORD_LOG2-1:0]];
      OP_SET: store_flag(index, value);
      OP_FIND, OP_POP: begin
        if (search_lowest(hit)) begin
          r.first_index = hit;
          if (op == OP_POP) store_flag(hit, 1'b0);
        end else begin
          r.is_empty = 1'b1;
        end
      end
      OP_FILL: fill_pyramid(value);
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch reporting and response checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    errors++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Sampled at the edge, so values are those the beat was taken with.
  always @(posedge clk) begin : check_beat
    rsp_beat_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (expected_rsp.size() == 0) begin
        report_mismatch($sformatf("response beat with nothing pending (idx %0d empty %0b)",
                                  rsp_if.first_index, rsp_if.is_empty));
      end else begin
        want = expected_rsp.pop_front();
        beats_checked++;
        if (want.is_empty) empty_searches++;
        if (rsp_if.bit_state !== want.bit_state)
          report_mismatch($sformatf("bit_state %b, want %b (beat %0d)",
                                    rsp_if.bit_state, want.bit_state, beats_checked));
        if (rsp_if.first_index !== want.first_index)
          report_mismatch($sformatf("first_index %0d, want %0d (beat %0d)",
                                    rsp_if.first_index, want.first_index, beats_checked));
        if (rsp_if.is_empty !== want.is_empty)
          report_mismatch($sformatf("is_empty %b, want %b (beat %0d)",
                                    rsp_if.is_empty, want.is_empty, beats_checked));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall before each beat, or a long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : rsp_sink
    int pause;
    rsp_if.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (sink_hold_cycles > 0) begin
        pause = sink_hold_cycles;
        sink_hold_cycles = 0;
        holds_done++;
      end else begin
        pause = no_idle ? 0 : $urandom_range(0, 12);
      end
      if (pause > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: one request beat, with a random gap ahead of it. valid is only
  // dropped when a gap follows, so back-to-back beats keep it high.
  // ---------------------------------------------------------------------------
  task automatic send_item(op_t op, pos_t index, logic value);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.op    <= op;
    req_if.index <= index;
    req_if.value <= value;
    do @(posedge clk); while (!req_if.ready);
    expected_rsp.push_back(predict_bitmap(op, index, value));
    op_seen[op]++;
    sent_total++;
  endtask

  // Index near a region base: mostly within four flag words of one summary
  // word, so words empty and refill often; sometimes spread wider or anywhere.
  function automatic pos_t pick_near(pos_t base);
    case ($urandom_range(0, 5))
      0:       return pos_t'($urandom);
      1:       return {base[MAP_LOG2-1:10], 10'($urandom)};
      default: return base + pos_t'($urandom_range(0, 63));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fresh map after reset: nothing set anywhere.
  task automatic test_empty_after_reset();
    send_item(OP_FIND, '0, 1'b0);
    send_item(OP_POP, '1, 1'b1);
    send_item(OP_GET, '1, 1'b0);
  endtask

  // Extreme indexes, every op, emptying of a whole branch, a clear that leaves
  // its word non-empty, set all both ways and the unassigned op codes.
  task automatic test_directed_edges();
    send_item(OP_SET, '1, 1'b1);
    send_item(OP_SET, '0, 1'b1);
    send_item(OP_GET, '0, 1'b0);
    send_item(OP_GET, '1, 1'b1);
    send_item(OP_FIND, '1, 1'b1);
    send_item(OP_POP, '0, 1'b0);
    send_item(OP_FIND, '0, 1'b0);
    send_item(OP_SET, '1, 1'b0);         // last flag gone: top word empties
    send_item(OP_FIND, '0, 1'b1);
    send_item(OP_SET, pos_t'(17), 1'b1);
    send_item(OP_SET, pos_t'(18), 1'b1);
    send_item(OP_SET, pos_t'(17), 1'b0); // word stays non-empty
    send_item(OP_FIND, '0, 1'b0);
    send_item(OP_FILL, '0, 1'b1);
    send_item(OP_GET, pos_t'(2049), 1'b0);
    send_item(OP_POP, '1, 1'b0);
    send_item(OP_FIND, '0, 1'b0);
    send_item(OP_FILL, '1, 1'b0);
    send_item(OP_FIND, '1, 1'b1);
    for (int c = OP_RSVD_FIRST; c <= OP_RSVD_LAST; c++)
      send_item(op_t'(c), pos_t'($urandom), 1'($urandom));
  endtask

  // Mostly build-and-drain episodes around a moving region, with noise,
  // set-all episodes and some back-to-back stretches mixed in.
  task automatic test_random_mix(int item_goal);
    int   start;
    int   k;
    pos_t base;
    start = sent_total;
    while (sent_total - start < item_goal) begin
      no_idle = ($urandom_range(0, 3) == 0);
      base    = pos_t'($urandom);
      case ($urandom_range(0, 9))
        0: begin
          // noise: any op, any field, reserved codes included
          repeat (8)
            send_item(op_t'($urandom_range(0, 7)), pos_t'($urandom), 1'($urandom));
        end
        1: begin
          send_item(OP_FILL, pos_t'($urandom), ($urandom_range(0, 3) == 0));
          repeat (4)
            send_item($urandom_range(0, 1) ? OP_POP : OP_GET, pick_near(base), 1'($urandom));
        end
        default: begin
          k = $urandom_range(1, 10);
          repeat (k) send_item(OP_SET, pick_near(base), 1'b1);
          repeat ($urandom_range(0, 4)) send_item(OP_GET, pick_near(base), 1'($urandom));
          if ($urandom_range(0, 2) == 0) send_item(OP_SET, pick_near(base), 1'b0);
          repeat (k + $urandom_range(0, 2))
            send_item(($urandom_range(0, 3) == 0) ? OP_FIND : OP_POP,
                      pos_t'($urandom), 1'($urandom));
        end
      endcase
    end
    no_idle = 1'b0;
  endtask

  // Receiver holds off for a long stretch while requests keep coming: the
  // output register fills, the next request is taken, then req.ready drops.
  task automatic test_output_backpressure();
    no_idle = 1'b1;
    repeat (2) begin
      sink_hold_cycles = 160;
      repeat (6) send_item(OP_SET, pos_t'($urandom), 1'b1);
      repeat (6) send_item(OP_POP, pos_t'($urandom), 1'b0);
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int other_ops;
    rst          <= 1'b1;
    req_if.valid <= 1'b0;
    req_if.op    <= OP_GET;
    req_if.index <= '0;
    req_if.value <= 1'b0;
    fill_pyramid(1'b0);
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_empty_after_reset();
    test_directed_edges();
    test_random_mix(1100);
    test_output_backpressure();
    req_if.valid <= 1'b0;

    // Drain, then keep watching for any stray beat to show itself.
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    other_ops = 0;
    for (int c = OP_RSVD_FIRST; c <= OP_RSVD_LAST; c++) other_ops += op_seen[op_t'(c)];
    $display("covered %0d requests: get %0d, set %0d, find %0d, pop %0d, set-all %0d, other %0d",
             sent_total, op_seen[OP_GET], op_seen[OP_SET], op_seen[OP_FIND],
             op_seen[OP_POP], op_seen[OP_FILL], other_ops);
    $display("%0d response beats checked, %0d empty searches, %0d long receiver hold-offs",
             beats_checked, empty_searches, holds_done);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Ends the run with a failure if the sequence hangs.
  initial begin : watchdog
    #2000000;
    $display("timeout with %0d beats outstanding", expected_rsp.size());
    $display("FAIL");
    $finish;
  end

endmodule
